### rtl/ibpc_pkg.sv
// Package for the image buffer pool cache: widths, codes, state and command types.
// Used by every module of the block; depends on nothing.
package ibpc_pkg;

    localparam int POOL_ENTRIES_DEF = 16;
    localparam int HANDLE_BITS_DEF  = 16;
    localparam int OUT_HANDLE_BITS  = 16;
    localparam int TOTAL_BITS       = 36;
    localparam logic [30:0] BYTES_RESET = 31'(1024 * 1024 * 1024);

    // Item kinds.
    localparam logic [1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_FLUSH   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_REUSED   = 3'd0;
    localparam logic [2:0] ST_CREATED  = 3'd1;
    localparam logic [2:0] ST_FAILED   = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FLUSHED  = 3'd5;

    // Configuration register indexes.
    localparam logic REG_MAX_ENTRIES = 1'b0;
    localparam logic REG_MAX_BYTES   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM_CHK,
        S_TRIM,
        S_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture the input beat, clear the scan index
        logic scan_step;  // test one entry and advance
        logic append;     // append a new entry after a miss
        logic trim_start; // clear the compaction pointers
        logic trim_step;  // move one entry during compaction
        logic trim_done;  // commit the compacted count
        logic out_load;   // latch the result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] kind;
        logic       scan_end;  // scan index reached the count
        logic       scan_hit;  // current entry matches
        logic       can_add;   // table has room and creation allowed
        logic       over;      // a limit is exceeded
        logic       trim_end;  // compaction has read every entry
    } t_stat;

endpackage

### rtl/image_buffer_pool_cache_top.sv
// Top level of the image buffer pool cache: stream ports, config port, assertions.
// Depends on ibpc_pkg, ibpc_ctrl and ibpc_dp.
//
// One beat at a time is processed. An acquire or release scans the table one
// entry per cycle (up to the entry count); a trim, when a limit is exceeded,
// walks the table once more, one entry per cycle, compacting survivors in
// order. The result waits in an output register, and the next beat is taken
// while it waits.
module image_buffer_pool_cache_top import ibpc_pkg::*; #(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    parameter int HANDLE_BITS  = HANDLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[1:0], pixel_depth[7:2], want_width[23:8], want_height[39:24],
    // new_bytes[71:40], create_ok[72], create_shared[73], release_handle[89:74]
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], handle[18:3], is_shared[19], entries_now[24:20], bytes_now[60:25]
    output logic [63:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [30:0]  i_cfg_data
);

    localparam int CW = $clog2(POOL_ENTRIES + 1);

    t_cmd  cmd;
    t_stat stat;
    logic [2:0]                 status;
    logic [OUT_HANDLE_BITS-1:0] handle;
    logic                       shared;
    logic [CW-1:0]              entries;
    logic [TOTAL_BITS-1:0]      bytes_now;

    ibpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ibpc_dp #(.POOL_ENTRIES(POOL_ENTRIES), .HANDLE_BITS(HANDLE_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (s_axis_tdata[1:0]),
        .i_depth         (s_axis_tdata[7:2]),
        .i_width         (s_axis_tdata[23:8]),
        .i_height        (s_axis_tdata[39:24]),
        .i_bytes         (s_axis_tdata[71:40]),
        .i_create_ok     (s_axis_tdata[72]),
        .i_create_shared (s_axis_tdata[73]),
        .i_rel_handle    (s_axis_tdata[89:74]),
        .o_status        (status),
        .o_handle        (handle),
        .o_shared        (shared),
        .o_entries       (entries),
        .o_bytes         (bytes_now)
    );

    assign m_axis_tdata = {3'b0, bytes_now, 5'(entries), shared, handle, status};

    // A result is never overwritten while it is still waiting.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("pending result changed");

    // The entry count never exceeds the table depth.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[24:20]) <= POOL_ENTRIES)
        else $error("entry count beyond table depth");

    // At most one of load, append, trim_step, trim_done and out_load is issued in a cycle.
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.append, cmd.trim_step, cmd.trim_done, cmd.out_load}))
        else $error("conflicting commands");

endmodule

### rtl/ibpc_ctrl.sv
// Controller state machine of the image buffer pool cache.
// Depends on ibpc_pkg for the state, command and status types.
module ibpc_ctrl import ibpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_out_valid = r_valid;
    assign o_in_ready  = (r_state == S_IDLE);

    // Next state and commands. The finished result sits in the output register
    // while the next beat is taken; a new result waits only if the old one stays.
    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_out_ready;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.kind == KIND_FLUSH) begin
                    n_state = S_TRIM_CHK;
                end else if (i_stat.kind inside {KIND_ACQUIRE, KIND_RELEASE}) begin
                    if (i_stat.scan_end) begin
                        if (i_stat.kind == KIND_ACQUIRE && i_stat.can_add) begin
                            o_cmd.append = 1'b1;
                            n_state = S_TRIM_CHK;
                        end else begin
                            n_state = S_OUT;
                        end
                    end else if (i_stat.scan_hit) begin
                        o_cmd.scan_step = 1'b1;
                        n_state = (i_stat.kind == KIND_ACQUIRE) ? S_OUT : S_TRIM_CHK;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_TRIM_CHK: begin
                o_cmd.trim_start = 1'b1;
                n_state = i_stat.over ? S_TRIM : S_OUT;
            end
            S_TRIM: begin
                if (i_stat.trim_end) begin
                    o_cmd.trim_done = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.trim_step = 1'b1;
                end
            end
            S_OUT: begin
                if (!r_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/ibpc_dp.sv
// Datapath of the image buffer pool cache: entry table, counters and result register.
// Depends on ibpc_pkg for the command and status types and result codes.
module ibpc_dp import ibpc_pkg::*; #(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    parameter int HANDLE_BITS  = HANDLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [30:0]                i_cfg_data,
    input  logic [1:0]                 i_kind,
    input  logic [5:0]                 i_depth,
    input  logic [15:0]                i_width,
    input  logic [15:0]                i_height,
    input  logic [31:0]                i_bytes,
    input  logic                       i_create_ok,
    input  logic                       i_create_shared,
    input  logic [15:0]                i_rel_handle,
    output logic [2:0]                 o_status,
    output logic [OUT_HANDLE_BITS-1:0] o_handle,
    output logic                       o_shared,
    output logic [$clog2(POOL_ENTRIES+1)-1:0] o_entries,
    output logic [TOTAL_BITS-1:0]      o_bytes
);

    localparam int IW = $clog2(POOL_ENTRIES);
    localparam int CW = $clog2(POOL_ENTRIES + 1);

    typedef struct packed {
        logic                   busy;
        logic [5:0]             depth;
        logic [15:0]            width;
        logic [15:0]            height;
        logic [31:0]            bytes;
        logic                   shared;
        logic [HANDLE_BITS-1:0] handle;
    } t_entry;

    t_entry                 r_tab [POOL_ENTRIES];
    logic [CW-1:0]          r_count;
    logic [TOTAL_BITS-1:0]  r_total;
    logic [HANDLE_BITS-1:0] r_next;
    logic [4:0]             r_max_ent;
    logic [30:0]            r_max_bytes;
    logic [CW-1:0]          r_idx, r_dst;
    logic [1:0]             r_kind;
    logic [5:0]             r_depth;
    logic [15:0]            r_width, r_height, r_rel;
    logic [31:0]            r_bytes;
    logic                   r_ok, r_shr;
    logic [2:0]             r_status;
    logic [OUT_HANDLE_BITS-1:0] r_hdl;
    logic                   r_hshr;

    t_entry cur;
    logic   hit_acq, hit_rel;

    assign cur = r_tab[r_idx[IW-1:0]];
    assign hit_acq = !cur.busy && cur.depth == r_depth &&
                     cur.width >= r_width && cur.height >= r_height;
    assign hit_rel = (cur.handle == HANDLE_BITS'(r_rel));

    assign o_stat.kind     = r_kind;
    assign o_stat.scan_end = (r_idx >= r_count);
    assign o_stat.scan_hit = (r_kind == KIND_ACQUIRE) ? hit_acq : hit_rel;
    assign o_stat.can_add  = r_ok && (r_count < CW'(POOL_ENTRIES));
    assign o_stat.over     = (r_total > TOTAL_BITS'(r_max_bytes)) ||
                             (32'(r_count) > 32'(r_max_ent));
    assign o_stat.trim_end = (r_idx >= r_count);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ent   <= '0;
            r_max_bytes <= BYTES_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MAX_ENTRIES) r_max_ent <= i_cfg_data[4:0];
            else                              r_max_bytes <= i_cfg_data;
        end
    end

    // Captured input beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_depth  <= i_depth;
            r_width  <= i_width;
            r_height <= i_height;
            r_bytes  <= i_bytes;
            r_ok     <= i_create_ok;
            r_shr    <= i_create_shared;
            r_rel    <= i_rel_handle;
        end
    end

    // Counters, scan and compaction pointers, and the result being built.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_next  <= '0;
            r_idx   <= '0;
            r_dst   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_hshr   <= 1'b0;
                r_status <= (i_kind == KIND_RELEASE) ? ST_NOTFOUND :
                            (i_kind == KIND_FLUSH) ? ST_FLUSHED : ST_FAILED;
                r_hdl    <= (i_kind == KIND_RELEASE) ? OUT_HANDLE_BITS'(i_rel_handle) : '0;
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
                if (o_stat.scan_hit) begin
                    if (r_kind == KIND_ACQUIRE) begin
                        r_status <= ST_REUSED;
                        r_hdl    <= OUT_HANDLE_BITS'(cur.handle);
                        r_hshr   <= cur.shared;
                    end else begin
                        r_status <= ST_RELEASED;
                    end
                end
            end
            if (i_cmd.append) begin
                r_status <= ST_CREATED;
                r_hdl    <= OUT_HANDLE_BITS'(r_next);
                r_hshr   <= r_shr;
                r_next   <= r_next + 1'b1;
                r_count  <= r_count + 1'b1;
                r_total  <= r_total + TOTAL_BITS'(r_bytes);
            end
            if (i_cmd.trim_start) begin
                r_idx <= '0;
                r_dst <= '0;
            end
            if (i_cmd.trim_step) begin
                r_idx <= r_idx + 1'b1;
                if (!cur.busy) r_total <= r_total - TOTAL_BITS'(cur.bytes);
                else           r_dst   <= r_dst + 1'b1;
            end
            if (i_cmd.trim_done) r_count <= r_dst;
        end
    end

    // Entry table writes: mark on hit, append, and compaction moves.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && o_stat.scan_hit) begin
            r_tab[r_idx[IW-1:0]].busy <= (r_kind == KIND_ACQUIRE);
        end
        if (i_cmd.append) begin
            r_tab[r_count[IW-1:0]] <= '{busy: 1'b1, depth: r_depth, width: r_width,
                                        height: r_height, bytes: r_bytes,
                                        shared: r_shr, handle: r_next};
        end
        if (i_cmd.trim_step && cur.busy) begin
            r_tab[r_dst[IW-1:0]] <= cur;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status  <= r_status;
            o_handle  <= r_hdl;
            o_shared  <= r_hshr;
            o_entries <= r_count;
            o_bytes   <= r_total;
        end
    end

endmodule
